### hdl/shkfsm_pkg.sv
// shared constants, codes and types of the session keep-alive controller
`default_nettype none

package shkfsm_pkg;

   // widths
   localparam int TIME_WIDTH_DEFAULT = 48;
   localparam int INTERVAL_WIDTH     = 16;
   localparam int SEQ_WIDTH          = 32;
   localparam int CSR_INDEX_WIDTH    = 2;
   localparam int CSR_DATA_WIDTH     = 32;

   // request kinds
   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_PACKET = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;

   // session phases
   localparam logic [1:0] PH_INIT = 2'd0;
   localparam logic [1:0] PH_DISC = 2'd1;
   localparam logic [1:0] PH_CHAL = 2'd2;
   localparam logic [1:0] PH_CONN = 2'd3;

   // received packet types
   localparam logic [2:0] PKT_RESPONSE   = 3'd0;
   localparam logic [2:0] PKT_PAYLOAD    = 3'd2;
   localparam logic [2:0] PKT_DISCONNECT = 3'd3;

   // send codes
   localparam logic [1:0] SEND_NONE       = 2'd0;
   localparam logic [1:0] SEND_DISCONNECT = 2'd1;
   localparam logic [1:0] SEND_CHALLENGE  = 2'd2;
   localparam logic [1:0] SEND_KEEPALIVE  = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONNECT_TIMEOUT    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RETRY_INTERVAL     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEEPALIVE_INTERVAL = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_SEQUENCE  = 2'd3;

   // register reset values
   localparam logic [INTERVAL_WIDTH-1:0] CONNECT_TIMEOUT_RESET    = 16'd5000;
   localparam logic [INTERVAL_WIDTH-1:0] RETRY_INTERVAL_RESET     = 16'd1000;
   localparam logic [INTERVAL_WIDTH-1:0] KEEPALIVE_INTERVAL_RESET = 16'd1000;
   localparam logic [SEQ_WIDTH-1:0]      EXPECTED_SEQUENCE_RESET  = 32'd0;

   // configuration register set
   typedef struct packed {
      logic [INTERVAL_WIDTH-1:0] connect_timeout;
      logic [INTERVAL_WIDTH-1:0] retry_interval;
      logic [INTERVAL_WIDTH-1:0] keepalive_interval;
      logic [SEQ_WIDTH-1:0]      expected_sequence;
   } cfg_type;

   // one result
   typedef struct packed {
      logic [1:0] send_request;
      logic [1:0] session_phase;
      logic       connected_notice;
      logic       disconnected_notice;
      logic       payload_deliver;
   } result_type;

endpackage

`default_nettype wire

### hdl/shkfsm_csr.sv
// configuration registers of the session keep-alive controller
`default_nettype none

module shkfsm_csr (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     wr_en,
   input  wire logic [shkfsm_pkg::CSR_INDEX_WIDTH-1:0]   wr_index,
   input  wire logic [shkfsm_pkg::CSR_DATA_WIDTH-1:0]    wr_data,
   output shkfsm_pkg::cfg_type                           cfg
);

   shkfsm_pkg::cfg_type cfg_ff;
   shkfsm_pkg::cfg_type cfg_in;

   // index decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            shkfsm_pkg::CSR_CONNECT_TIMEOUT:
               cfg_in.connect_timeout = wr_data[shkfsm_pkg::INTERVAL_WIDTH-1:0];
            shkfsm_pkg::CSR_RETRY_INTERVAL:
               cfg_in.retry_interval = wr_data[shkfsm_pkg::INTERVAL_WIDTH-1:0];
            shkfsm_pkg::CSR_KEEPALIVE_INTERVAL:
               cfg_in.keepalive_interval = wr_data[shkfsm_pkg::INTERVAL_WIDTH-1:0];
            shkfsm_pkg::CSR_EXPECTED_SEQUENCE:
               cfg_in.expected_sequence = wr_data[shkfsm_pkg::SEQ_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.connect_timeout    <= shkfsm_pkg::CONNECT_TIMEOUT_RESET;
         cfg_ff.retry_interval     <= shkfsm_pkg::RETRY_INTERVAL_RESET;
         cfg_ff.keepalive_interval <= shkfsm_pkg::KEEPALIVE_INTERVAL_RESET;
         cfg_ff.expected_sequence  <= shkfsm_pkg::EXPECTED_SEQUENCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hdl/shkfsm_step.sv
// next-state and result logic for one session event
`default_nettype none

module shkfsm_step #(
   parameter int TIME_WIDTH = shkfsm_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire shkfsm_pkg::cfg_type            cfg,
   input  wire logic [1:0]                     kind,
   input  wire logic [TIME_WIDTH-1:0]          now,
   input  wire logic [2:0]                     packet_type,
   input  wire logic [shkfsm_pkg::SEQ_WIDTH-1:0] response_sequence,
   input  wire logic                           token_equal,
   input  wire logic [1:0]                     phase_cur,
   input  wire logic [TIME_WIDTH-1:0]          next_send_cur,
   input  wire logic [TIME_WIDTH-1:0]          give_up_cur,
   input  wire logic [TIME_WIDTH-1:0]          last_receive_cur,
   output logic [1:0]                          phase_nxt,
   output logic [TIME_WIDTH-1:0]               next_send_nxt,
   output logic [TIME_WIDTH-1:0]               give_up_nxt,
   output logic [TIME_WIDTH-1:0]               last_receive_nxt,
   output shkfsm_pkg::result_type              result
);

   localparam int IW = shkfsm_pkg::INTERVAL_WIDTH;
   localparam logic [TIME_WIDTH:0] IPAD = '0;

   logic [IW-1:0]         send_interval;
   logic [TIME_WIDTH:0]   next_send_sum;
   logic [TIME_WIDTH:0]   give_up_sum;
   logic [TIME_WIDTH:0]   silence_sum;
   logic [TIME_WIDTH-1:0] next_send_adv;
   logic [TIME_WIDTH-1:0] give_up_new;
   logic [TIME_WIDTH-1:0] silence_limit;
   logic                  give_up_hit;
   logic                  silence_hit;
   logic                  send_due;
   logic                  response_ok;

   // saturating time sums: a carry out clamps to all ones
   assign send_interval = (phase_cur == shkfsm_pkg::PH_CONN) ? cfg.keepalive_interval
                                                              : cfg.retry_interval;
   assign next_send_sum = {1'b0, next_send_cur}
                          + (IPAD | (TIME_WIDTH+1)'(send_interval));
   assign give_up_sum   = {1'b0, now} + (IPAD | (TIME_WIDTH+1)'(cfg.connect_timeout));
   assign silence_sum   = {1'b0, last_receive_cur}
                          + (IPAD | (TIME_WIDTH+1)'(cfg.connect_timeout));
   assign next_send_adv = next_send_sum[TIME_WIDTH] ? '1 : next_send_sum[TIME_WIDTH-1:0];
   assign give_up_new   = give_up_sum[TIME_WIDTH]   ? '1 : give_up_sum[TIME_WIDTH-1:0];
   assign silence_limit = silence_sum[TIME_WIDTH]   ? '1 : silence_sum[TIME_WIDTH-1:0];

   // deadline checks
   assign give_up_hit = (now >= give_up_cur);
   assign silence_hit = (now >= silence_limit);
   assign send_due    = (now >= next_send_cur);
   assign response_ok = (packet_type == shkfsm_pkg::PKT_RESPONSE)
                        && (response_sequence == cfg.expected_sequence) && token_equal;

   // event handling per phase
   always_comb begin
      phase_nxt        = phase_cur;
      next_send_nxt    = next_send_cur;
      give_up_nxt      = give_up_cur;
      last_receive_nxt = last_receive_cur;
      result           = '0;
      result.send_request = shkfsm_pkg::SEND_NONE;

      unique case (kind)
         shkfsm_pkg::KIND_TICK: begin
            unique case (phase_cur)
               shkfsm_pkg::PH_DISC: begin
                  if (give_up_hit) begin
                     phase_nxt = shkfsm_pkg::PH_INIT;
                     result.disconnected_notice = 1'b1;
                  end else if (send_due) begin
                     next_send_nxt = next_send_adv;
                     result.send_request = shkfsm_pkg::SEND_DISCONNECT;
                  end
               end
               shkfsm_pkg::PH_CHAL: begin
                  if (give_up_hit) begin
                     phase_nxt     = shkfsm_pkg::PH_DISC;
                     next_send_nxt = now;
                     give_up_nxt   = give_up_new;
                  end else if (send_due) begin
                     next_send_nxt = next_send_adv;
                     result.send_request = shkfsm_pkg::SEND_CHALLENGE;
                  end
               end
               shkfsm_pkg::PH_CONN: begin
                  if (silence_hit) begin
                     phase_nxt     = shkfsm_pkg::PH_DISC;
                     next_send_nxt = now;
                     give_up_nxt   = give_up_new;
                  end else if (send_due) begin
                     next_send_nxt = next_send_adv;
                     result.send_request = shkfsm_pkg::SEND_KEEPALIVE;
                  end
               end
               default: ;
            endcase
         end
         shkfsm_pkg::KIND_PACKET: begin
            unique case (phase_cur)
               shkfsm_pkg::PH_CHAL: begin
                  if (response_ok) begin
                     phase_nxt        = shkfsm_pkg::PH_CONN;
                     next_send_nxt    = now;
                     last_receive_nxt = now;
                     result.connected_notice = 1'b1;
                  end
               end
               shkfsm_pkg::PH_CONN: begin
                  last_receive_nxt = now;
                  if (packet_type == shkfsm_pkg::PKT_PAYLOAD) begin
                     result.payload_deliver = 1'b1;
                  end else if (packet_type == shkfsm_pkg::PKT_DISCONNECT) begin
                     phase_nxt     = shkfsm_pkg::PH_DISC;
                     next_send_nxt = now;
                     give_up_nxt   = give_up_new;
                  end
               end
               default: ;
            endcase
         end
         shkfsm_pkg::KIND_START: begin
            result.disconnected_notice = (phase_cur == shkfsm_pkg::PH_DISC);
            phase_nxt     = shkfsm_pkg::PH_CHAL;
            next_send_nxt = now;
            give_up_nxt   = give_up_new;
         end
         default: ;
      endcase

      result.session_phase = phase_nxt;
   end

endmodule

`default_nettype wire

### hdl/session_handshake_keepalive_fsm_core.sv
// Server-side session controller: retries, keep-alives and timeouts per time-stamped event.
// Takes one request per clock cycle and returns exactly one result per request. A request
// is captured in an input register, the phase and the three time stamps are updated by a
// single pass of compare and saturating-add logic, and the result lands in an output
// register. Throughput is one request per cycle; it drops only while the result side
// holds off rsp_ready. The configuration port takes a write in any cycle and should be
// written only while idle.
`default_nettype none

module session_handshake_keepalive_fsm_core #(
   parameter int TIME_WIDTH = shkfsm_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // configuration writes
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [shkfsm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [shkfsm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   // event requests
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic [1:0]                              req_kind,
   input  wire logic [TIME_WIDTH-1:0]                   req_now,
   input  wire logic [2:0]                              req_packet_type,
   input  wire logic [shkfsm_pkg::SEQ_WIDTH-1:0]        req_response_sequence,
   input  wire logic                                    req_token_equal,
   // results
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic [1:0]                                   rsp_send_request,
   output logic [1:0]                                   rsp_session_phase,
   output logic                                         rsp_connected_notice,
   output logic                                         rsp_disconnected_notice,
   output logic                                         rsp_payload_deliver
);

   shkfsm_pkg::cfg_type    cfg;
   shkfsm_pkg::result_type step_result;

   logic                                 s1_valid_ff, s1_valid_in;
   logic [1:0]                           s1_kind_ff;
   logic [TIME_WIDTH-1:0]                s1_now_ff;
   logic [2:0]                           s1_packet_type_ff;
   logic [shkfsm_pkg::SEQ_WIDTH-1:0]     s1_response_sequence_ff;
   logic                                 s1_token_equal_ff;

   logic [1:0]            phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] next_send_ff, next_send_in;
   logic [TIME_WIDTH-1:0] give_up_ff, give_up_in;
   logic [TIME_WIDTH-1:0] last_receive_ff, last_receive_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   shkfsm_pkg::result_type rsp_ff;

   logic req_accept;
   logic advance;

   // configuration registers
   assign csr_ready = 1'b1;

   shkfsm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // handshake: the staged request moves on whenever the result slot is free or draining
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign req_accept   = req_valid && req_ready;
   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_kind_ff              <= req_kind;
         s1_now_ff               <= req_now;
         s1_packet_type_ff       <= req_packet_type;
         s1_response_sequence_ff <= req_response_sequence;
         s1_token_equal_ff       <= req_token_equal;
      end
   end

   // step logic
   shkfsm_step #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .cfg               (cfg),
      .kind              (s1_kind_ff),
      .now               (s1_now_ff),
      .packet_type       (s1_packet_type_ff),
      .response_sequence (s1_response_sequence_ff),
      .token_equal       (s1_token_equal_ff),
      .phase_cur         (phase_ff),
      .next_send_cur     (next_send_ff),
      .give_up_cur       (give_up_ff),
      .last_receive_cur  (last_receive_ff),
      .phase_nxt         (phase_in),
      .next_send_nxt     (next_send_in),
      .give_up_nxt       (give_up_in),
      .last_receive_nxt  (last_receive_in),
      .result            (step_result)
   );

   // session state, updated once per processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= shkfsm_pkg::PH_INIT;
         next_send_ff    <= '0;
         give_up_ff      <= '0;
         last_receive_ff <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         next_send_ff    <= next_send_in;
         give_up_ff      <= give_up_in;
         last_receive_ff <= last_receive_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_send_request        = rsp_ff.send_request;
   assign rsp_session_phase       = rsp_ff.session_phase;
   assign rsp_connected_notice    = rsp_ff.connected_notice;
   assign rsp_disconnected_notice = rsp_ff.disconnected_notice;
   assign rsp_payload_deliver     = rsp_ff.payload_deliver;

   // result matches the phase it reports
   a_connect_phase : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_connected_notice |-> rsp_session_phase == shkfsm_pkg::PH_CONN)
      else $error("connected notice without connected phase");

   a_disconnect_phase : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_disconnected_notice |->
         (rsp_session_phase == shkfsm_pkg::PH_INIT ||
          rsp_session_phase == shkfsm_pkg::PH_CHAL))
      else $error("disconnected notice with wrong phase");

   a_payload_quiet : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_deliver |->
         (rsp_session_phase == shkfsm_pkg::PH_CONN &&
          rsp_send_request == shkfsm_pkg::SEND_NONE))
      else $error("payload delivered outside connected phase");

   // a held result keeps the stage from moving, so the phase register stays put
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(phase_ff))
      else $error("session state changed while result stalled");

endmodule

`default_nettype wire

### tb/session_handshake_keepalive_fsm_core_tb.sv
// Self-checking testbench for the session keep-alive controller: directed and random event traffic
`timescale 1ns / 100ps

module session_handshake_keepalive_fsm_core_tb;

   localparam int TW           = shkfsm_pkg::TIME_WIDTH_DEFAULT;
   localparam int SW           = shkfsm_pkg::SEQ_WIDTH;
   localparam int IXW          = shkfsm_pkg::CSR_INDEX_WIDTH;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   // codes the package leaves out
   localparam logic [1:0] KIND_UNUSED    = 2'd3;
   localparam logic [2:0] PKT_KEEPALIVE  = 3'd1;
   localparam logic [2:0] PKT_OTHER      = 3'd4;
   localparam logic [2:0] PKT_OTHER_LAST = 3'd7;

   typedef logic [TW-1:0] stamp_type;
   localparam stamp_type STAMP_MAX = '1;

   typedef struct packed {
      logic [1:0]    kind;
      stamp_type     now;
      logic [2:0]    packet_type;
      logic [SW-1:0] response_sequence;
      logic          token_equal;
   } session_event_type;

   typedef enum int {SET_MINIMUM, SET_MAXIMUM, SET_SHORT, SET_ANY} setting_style_type;

   logic                                   clock;
   logic                                   reset;
   logic                                   csr_valid;
   logic                                   csr_ready;
   logic [IXW-1:0]                         csr_index;
   logic [shkfsm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;
   logic                                   req_valid;
   logic                                   req_ready;
   logic [1:0]                             req_kind;
   stamp_type                              req_now;
   logic [2:0]                             req_packet_type;
   logic [SW-1:0]                          req_response_sequence;
   logic                                   req_token_equal;
   logic                                   rsp_valid;
   logic                                   rsp_ready;
   logic [1:0]                             rsp_send_request;
   logic [1:0]                             rsp_session_phase;
   logic                                   rsp_connected_notice;
   logic                                   rsp_disconnected_notice;
   logic                                   rsp_payload_deliver;

   // predicted session state and register copy
   logic [1:0]          sess_phase;
   stamp_type           next_send_at;
   stamp_type           give_up_at;
   stamp_type           last_heard_at;
   shkfsm_pkg::cfg_type cfg_model;

   // settings the stimulus is shaped around
   shkfsm_pkg::cfg_type cfg_drive;

   shkfsm_pkg::result_type pending_outcomes[$];
   int         events_accepted = 0;
   int         outcomes_seen   = 0;
   int         mismatches      = 0;
   int         cycle_count     = 0;
   int         stall_left      = 0;
   bit         idle_on;

   session_handshake_keepalive_fsm_core u_top (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_kind                (req_kind),
      .req_now                 (req_now),
      .req_packet_type         (req_packet_type),
      .req_response_sequence   (req_response_sequence),
      .req_token_equal         (req_token_equal),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_send_request        (rsp_send_request),
      .rsp_session_phase       (rsp_session_phase),
      .rsp_connected_notice    (rsp_connected_notice),
      .rsp_disconnected_notice (rsp_disconnected_notice),
      .rsp_payload_deliver     (rsp_payload_deliver)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // time sum that sticks at the top of the time range
   function automatic stamp_type sat_sum(input stamp_type a, input longint unsigned b);
      logic [64:0] total;
      total = 65'(a) + 65'(b);
      return (total > 65'(STAMP_MAX)) ? STAMP_MAX : stamp_type'(total);
   endfunction

   function automatic stamp_type after_about(input stamp_type t, input int unsigned span);
      return sat_sum(t, $urandom_range(0, span + span / 2));
   endfunction

   // enter disconnected or challenging with fresh timers
   function automatic void restart_retries(input logic [1:0] target, input stamp_type t);
      sess_phase   = target;
      next_send_at = t;
      give_up_at   = sat_sum(t, cfg_model.connect_timeout);
   endfunction

   // session state update for one request, returns the result it causes
   function automatic shkfsm_pkg::result_type advance_session(input session_event_type ev);
      shkfsm_pkg::result_type outcome;
      outcome = '0;
      case (ev.kind)
         shkfsm_pkg::KIND_TICK: begin
            case (sess_phase)
               shkfsm_pkg::PH_DISC: begin
                  if (ev.now >= give_up_at) begin
                     sess_phase = shkfsm_pkg::PH_INIT;
                     outcome.disconnected_notice = 1'b1;
                  end else if (ev.now >= next_send_at) begin
                     next_send_at = sat_sum(next_send_at, cfg_model.retry_interval);
                     outcome.send_request = shkfsm_pkg::SEND_DISCONNECT;
                  end
               end
               shkfsm_pkg::PH_CHAL: begin
                  if (ev.now >= give_up_at) begin
                     restart_retries(shkfsm_pkg::PH_DISC, ev.now);
                  end else if (ev.now >= next_send_at) begin
                     next_send_at = sat_sum(next_send_at, cfg_model.retry_interval);
                     outcome.send_request = shkfsm_pkg::SEND_CHALLENGE;
                  end
               end
               shkfsm_pkg::PH_CONN: begin
                  if (ev.now >= sat_sum(last_heard_at, cfg_model.connect_timeout)) begin
                     restart_retries(shkfsm_pkg::PH_DISC, ev.now);
                  end else if (ev.now >= next_send_at) begin
                     next_send_at = sat_sum(next_send_at, cfg_model.keepalive_interval);
                     outcome.send_request = shkfsm_pkg::SEND_KEEPALIVE;
                  end
               end
               default: ;
            endcase
         end
         shkfsm_pkg::KIND_PACKET: begin
            if (sess_phase == shkfsm_pkg::PH_CHAL) begin
               if (ev.packet_type == shkfsm_pkg::PKT_RESPONSE && ev.token_equal &&
                   ev.response_sequence == cfg_model.expected_sequence) begin
                  sess_phase    = shkfsm_pkg::PH_CONN;
                  next_send_at  = ev.now;
                  last_heard_at = ev.now;
                  outcome.connected_notice = 1'b1;
               end
            end else if (sess_phase == shkfsm_pkg::PH_CONN) begin
               last_heard_at = ev.now;
               if (ev.packet_type == shkfsm_pkg::PKT_PAYLOAD)
                  outcome.payload_deliver = 1'b1;
               else if (ev.packet_type == shkfsm_pkg::PKT_DISCONNECT)
                  restart_retries(shkfsm_pkg::PH_DISC, ev.now);
            end
         end
         shkfsm_pkg::KIND_START: begin
            if (sess_phase == shkfsm_pkg::PH_DISC)
               outcome.disconnected_notice = 1'b1;
            restart_retries(shkfsm_pkg::PH_CHAL, ev.now);
         end
         default: ;
      endcase
      outcome.session_phase = sess_phase;
      return outcome;
   endfunction

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
      end
   endtask

   // register writes, accepted requests and results, all sampled at the edge
   always @(posedge clock) begin
      shkfsm_pkg::result_type want;
      if (reset) begin
         cfg_model.connect_timeout    = shkfsm_pkg::CONNECT_TIMEOUT_RESET;
         cfg_model.retry_interval     = shkfsm_pkg::RETRY_INTERVAL_RESET;
         cfg_model.keepalive_interval = shkfsm_pkg::KEEPALIVE_INTERVAL_RESET;
         cfg_model.expected_sequence  = shkfsm_pkg::EXPECTED_SEQUENCE_RESET;
         sess_phase    = shkfsm_pkg::PH_INIT;
         next_send_at  = '0;
         give_up_at    = '0;
         last_heard_at = '0;
         pending_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               shkfsm_pkg::CSR_CONNECT_TIMEOUT:
                  cfg_model.connect_timeout    = csr_wdata[15:0];
               shkfsm_pkg::CSR_RETRY_INTERVAL:
                  cfg_model.retry_interval     = csr_wdata[15:0];
               shkfsm_pkg::CSR_KEEPALIVE_INTERVAL:
                  cfg_model.keepalive_interval = csr_wdata[15:0];
               shkfsm_pkg::CSR_EXPECTED_SEQUENCE:
                  cfg_model.expected_sequence  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pending_outcomes.push_back(advance_session('{req_kind, req_now, req_packet_type,
                                                         req_response_sequence,
                                                         req_token_equal}));
         if (rsp_valid && rsp_ready) begin
            outcomes_seen++;
            if (pending_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t: result expected none actual phase %0d send %0d",
                        $time, rsp_session_phase, rsp_send_request);
            end else begin
               want = pending_outcomes.pop_front();
               check_field("send_request", want.send_request, rsp_send_request);
               check_field("session_phase", want.session_phase, rsp_session_phase);
               check_field("connected_notice", want.connected_notice, rsp_connected_notice);
               check_field("disconnected_notice", want.disconnected_notice,
                           rsp_disconnected_notice);
               check_field("payload_deliver", want.payload_deliver, rsp_payload_deliver);
            end
         end
      end
   end

   // result side stalls in bursts
   always @(posedge clock) begin
      if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 9);
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // one request, with an optional gap before it
   task automatic send_event(input logic [1:0] kind, input stamp_type t,
                             input logic [2:0] ptype, input logic [SW-1:0] rseq,
                             input logic teq);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_kind              <= kind;
      req_now               <= t;
      req_packet_type       <= ptype;
      req_response_sequence <= rseq;
      req_token_equal       <= teq;
      do @(posedge clock); while (!req_ready);
      events_accepted++;
   endtask

   // tick, start or unused kind: packet fields carry noise
   task automatic send_bare(input logic [1:0] kind, input stamp_type t);
      send_event(kind, t, 3'($urandom), $urandom, 1'($urandom));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outcomes_seen != events_accepted);
   endtask

   // all four registers, once the block has drained
   task automatic write_registers(input shkfsm_pkg::cfg_type c);
      logic [shkfsm_pkg::CSR_DATA_WIDTH-1:0] wdata [4];
      wait_idle();
      cfg_drive = c;
      wdata[shkfsm_pkg::CSR_CONNECT_TIMEOUT]    = {16'($urandom), c.connect_timeout};
      wdata[shkfsm_pkg::CSR_RETRY_INTERVAL]     = {16'($urandom), c.retry_interval};
      wdata[shkfsm_pkg::CSR_KEEPALIVE_INTERVAL] = {16'($urandom), c.keepalive_interval};
      wdata[shkfsm_pkg::CSR_EXPECTED_SEQUENCE]  = c.expected_sequence;
      for (int i = 0; i < (1 << IXW); i++) begin
         csr_valid <= 1'b1;
         csr_index <= IXW'(i);
         csr_wdata <= wdata[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic shkfsm_pkg::cfg_type pick_settings(input setting_style_type style);
      shkfsm_pkg::cfg_type c;
      c.expected_sequence = $urandom;
      case (style)
         SET_MINIMUM: begin
            c.connect_timeout    = 16'd1;
            c.retry_interval     = 16'd1;
            c.keepalive_interval = 16'd1;
            c.expected_sequence  = '0;
         end
         SET_MAXIMUM: begin
            c.connect_timeout    = '1;
            c.retry_interval     = '1;
            c.keepalive_interval = '1;
            c.expected_sequence  = '1;
         end
         SET_SHORT: begin
            c.connect_timeout    = 16'($urandom_range(1, 400));
            c.retry_interval     = 16'($urandom_range(1, 100));
            c.keepalive_interval = 16'($urandom_range(1, 100));
         end
         default: begin
            c.connect_timeout    = 16'($urandom_range(1, 65535));
            c.retry_interval     = 16'($urandom_range(1, 65535));
            c.keepalive_interval = 16'($urandom_range(1, 65535));
         end
      endcase
      return c;
   endfunction

   // mostly whole sessions with random timing, some stray requests between them
   task automatic run_sessions(input int target);
      int            first;
      stamp_type     t;
      stamp_type     when;
      logic [SW-1:0] seq;
      logic [2:0]    ptype;
      first = events_accepted;
      t = ($urandom_range(0, 4) == 0) ? STAMP_MAX - $urandom_range(0, 300000)
                                      : stamp_type'({$urandom_range(0, 255), $urandom});
      while (events_accepted - first < target) begin
         if ($urandom_range(0, 99) < 15) begin
            // stray request of any kind at any time
            when = $urandom_range(0, 1) ? stamp_type'({$urandom, $urandom})
                                        : after_about(t, cfg_drive.retry_interval);
            seq  = ($urandom_range(0, 3) == 0) ? cfg_drive.expected_sequence : $urandom;
            send_event(2'($urandom), when, 3'($urandom), seq, 1'($urandom));
         end else begin
            // challenge with retries
            send_bare(shkfsm_pkg::KIND_START, t);
            repeat ($urandom_range(1, 4)) begin
               t = after_about(t, cfg_drive.retry_interval);
               send_bare(shkfsm_pkg::KIND_TICK, t);
            end
            if ($urandom_range(0, 9) == 0) begin
               // no answer until the deadline
               t = sat_sum(t, cfg_drive.connect_timeout + $urandom_range(0, 2));
               send_bare(shkfsm_pkg::KIND_TICK, t);
            end else begin
               // response, now and then with a bad sequence or token
               seq = cfg_drive.expected_sequence;
               if ($urandom_range(0, 9) == 0)
                  seq = seq ^ (32'd1 << $urandom_range(0, 31));
               t = after_about(t, cfg_drive.retry_interval / 4);
               send_event(shkfsm_pkg::KIND_PACKET, t, shkfsm_pkg::PKT_RESPONSE, seq,
                          $urandom_range(0, 9) != 0);
               // connected traffic
               repeat ($urandom_range(2, 10)) begin
                  t = after_about(t, cfg_drive.keepalive_interval);
                  if ($urandom_range(0, 1)) begin
                     send_bare(shkfsm_pkg::KIND_TICK, t);
                  end else begin
                     case ($urandom_range(0, 2))
                        0: ptype = PKT_KEEPALIVE;
                        1: ptype = shkfsm_pkg::PKT_PAYLOAD;
                        default: ptype = 3'($urandom_range(PKT_OTHER, PKT_OTHER_LAST));
                     endcase
                     send_event(shkfsm_pkg::KIND_PACKET, t, ptype, $urandom, 1'($urandom));
                  end
               end
               // end of the connection: disconnect packet, silence, or left open
               case ($urandom_range(0, 2))
                  0: send_event(shkfsm_pkg::KIND_PACKET, t, shkfsm_pkg::PKT_DISCONNECT,
                                $urandom, 1'($urandom));
                  1: begin
                     t = sat_sum(t, cfg_drive.connect_timeout + $urandom_range(0, 2));
                     send_bare(shkfsm_pkg::KIND_TICK, t);
                  end
                  default: ;
               endcase
            end
            // disconnect retries, often until the session gives up
            repeat ($urandom_range(0, 3)) begin
               t = after_about(t, cfg_drive.retry_interval);
               send_bare(shkfsm_pkg::KIND_TICK, t);
            end
            if ($urandom_range(0, 1)) begin
               t = sat_sum(t, cfg_drive.connect_timeout + $urandom_range(0, 2));
               send_bare(shkfsm_pkg::KIND_TICK, t);
            end
         end
      end
   endtask

   // full session life with reset settings, boundaries hit exactly
   task automatic test_session_walkthrough();
      send_bare(shkfsm_pkg::KIND_TICK, 48'd0);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd5, shkfsm_pkg::PKT_RESPONSE, 32'd0, 1'b1);
      send_bare(KIND_UNUSED, 48'd10);
      send_bare(shkfsm_pkg::KIND_START, 48'd100);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd100);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd1099);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd1100);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd1150, shkfsm_pkg::PKT_RESPONSE, 32'd1, 1'b1);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd1160, shkfsm_pkg::PKT_RESPONSE, 32'd0, 1'b0);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd1200, PKT_KEEPALIVE, 32'd0, 1'b1);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd1300, shkfsm_pkg::PKT_RESPONSE, 32'd0, 1'b1);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd1300);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd1500, shkfsm_pkg::PKT_PAYLOAD, 32'd0, 1'b0);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd1600, PKT_OTHER, 32'd0, 1'b0);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd1700, PKT_OTHER_LAST, 32'd0, 1'b0);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd2300);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd6700);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd6700);
      send_bare(shkfsm_pkg::KIND_START, 48'd7000);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd12000);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd12500, shkfsm_pkg::PKT_PAYLOAD, 32'd0, 1'b1);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd17000);
      send_bare(shkfsm_pkg::KIND_START, 48'd17500);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd17600, shkfsm_pkg::PKT_RESPONSE, 32'd0, 1'b1);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd17700, shkfsm_pkg::PKT_DISCONNECT, 32'd0,
                 1'b1);
   endtask

   // sums that run past the top of the time range
   task automatic test_time_saturation();
      write_registers(pick_settings(SET_MAXIMUM));
      send_bare(shkfsm_pkg::KIND_START, STAMP_MAX - 100);
      send_bare(shkfsm_pkg::KIND_TICK, STAMP_MAX - 100);
      send_bare(shkfsm_pkg::KIND_TICK, STAMP_MAX - 1);
      send_bare(shkfsm_pkg::KIND_TICK, STAMP_MAX);
      send_bare(shkfsm_pkg::KIND_START, STAMP_MAX);
      send_event(shkfsm_pkg::KIND_PACKET, STAMP_MAX - 50, shkfsm_pkg::PKT_RESPONSE, '1, 1'b1);
      send_bare(shkfsm_pkg::KIND_TICK, STAMP_MAX - 50);
      send_bare(shkfsm_pkg::KIND_TICK, STAMP_MAX);
   endtask

   // zero deadline gives up at once, zero intervals send on every tick
   task automatic test_zero_intervals();
      shkfsm_pkg::cfg_type c;
      c = '{connect_timeout: 16'd0, retry_interval: 16'd0, keepalive_interval: 16'd0,
            expected_sequence: 32'h8000_0001};
      write_registers(c);
      send_bare(shkfsm_pkg::KIND_START, 48'd500);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd500);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd500);
      c.connect_timeout = 16'd3;
      write_registers(c);
      send_bare(shkfsm_pkg::KIND_START, 48'd600);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd600);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd601);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd603);
      send_bare(shkfsm_pkg::KIND_START, 48'd700);
      send_event(shkfsm_pkg::KIND_PACKET, 48'd700, shkfsm_pkg::PKT_RESPONSE, 32'h8000_0001,
                 1'b1);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd701);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd702);
      send_bare(shkfsm_pkg::KIND_TICK, 48'd703);
   endtask

   task automatic test_random_sessions();
      setting_style_type plan [6] = '{SET_SHORT, SET_MINIMUM, SET_ANY, SET_MAXIMUM, SET_SHORT,
                                      SET_ANY};
      foreach (plan[i]) begin
         write_registers(pick_settings(plan[i]));
         run_sessions(110);
      end
   endtask

   // closing stretch at full rate, no gaps and no stalls
   task automatic test_back_to_back();
      idle_on = 1'b0;
      write_registers(pick_settings(SET_SHORT));
      run_sessions(90);
   endtask

   initial begin
      idle_on               = 1'b1;
      reset                 <= 1'b1;
      csr_valid             <= 1'b0;
      csr_index             <= '0;
      csr_wdata             <= '0;
      req_valid             <= 1'b0;
      req_kind              <= shkfsm_pkg::KIND_TICK;
      req_now               <= '0;
      req_packet_type       <= shkfsm_pkg::PKT_RESPONSE;
      req_response_sequence <= '0;
      req_token_equal       <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_session_walkthrough();
      test_time_saturation();
      test_zero_intervals();
      test_random_sessions();
      test_back_to_back();

      // drain, then allow for a stray late result
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0)
         $display("%0t: results expected %0d actual 0", $time, pending_outcomes.size());
      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### filelist.f
hdl/shkfsm_pkg.sv
hdl/shkfsm_csr.sv
hdl/shkfsm_step.sv
hdl/session_handshake_keepalive_fsm_core.sv
tb/session_handshake_keepalive_fsm_core_tb.sv
